>>> design/mmrc_pkg.sv
// mmrc_pkg: shared constants, types and the crc-16 byte update for the
// modbus reply checker. no dependencies.
`default_nettype none

package mmrc_pkg;

  localparam int FRAME_BYTES = 32;
  localparam int COUNT_W     = $clog2(FRAME_BYTES + 1);
  localparam int INDEX_W     = $clog2(FRAME_BYTES);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [7:0] BROADCAST_ADDR  = 8'hF8;
  localparam logic [7:0] RESET_EXP_ADDR  = 8'hF8;
  localparam logic [5:0] RESET_EXP_LEN   = 6'd23;
  localparam logic [COUNT_W-1:0] METRICS_LEN    = COUNT_W'(23);
  localparam logic [COUNT_W-1:0] MIN_WORD_LEN   = COUNT_W'(5);
  localparam logic [COUNT_W-1:0] MIN_FRAME_LEN  = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] STORE_LIMIT    = COUNT_W'(FRAME_BYTES);

  typedef enum logic [2:0] {
    STATUS_OK      = 3'd0,
    STATUS_TIMEOUT = 3'd1,
    STATUS_LENGTH  = 3'd2,
    STATUS_CRC     = 3'd3,
    STATUS_ADDRESS = 3'd4
  } status_t;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_END  = 1'b1
  } cmd_t;

  typedef enum logic {
    REG_EXP_ADDR = 1'b0,
    REG_EXP_LEN  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [7:0] expected_address;
    logic [5:0] expected_length;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0]           count;
    logic [15:0]                  crc;
    logic [FRAME_BYTES-1:0][7:0]  bytes;
  } frame_t;

  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/mmrc_frame.sv
// mmrc_frame: frame byte store, byte count and running crc of the reply.
// depends on mmrc_pkg.
`default_nettype none

module mmrc_frame
  import mmrc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       beat,
  input  logic       cmd,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output frame_t     frame
);

  logic [COUNT_W-1:0]          count;
  logic [15:0]                 crc;
  logic [FRAME_BYTES-1:0][7:0] store;
  logic                        take;

  assign take = beat && (cmd == CMD_BYTE) &&
                (count < COUNT_W'(cfg.expected_length)) && (count < STORE_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      crc   <= CRC_INIT;
    end else if (beat && (cmd == CMD_END)) begin
      count <= '0;
      crc   <= CRC_INIT;
    end else if (take) begin
      count <= count + COUNT_W'(1);
      crc   <= crc16_update(crc, rx_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      store[count[INDEX_W-1:0]] <= rx_byte;
    end
  end

  assign frame.count = count;
  assign frame.crc   = crc;
  assign frame.bytes = store;

endmodule

`default_nettype wire

>>> design/mmrc_result.sv
// mmrc_result: end-of-frame checks, address capture and the result register.
// depends on mmrc_pkg.
`default_nettype none

module mmrc_result
  import mmrc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         end_beat,
  input  frame_t       frame,
  input  cfg_t         cfg,
  input  logic         result_ready,
  output logic         result_valid,
  output logic [2:0]   status,
  output logic [7:0]   device_address,
  output logic [5:0]   byte_count,
  output logic [15:0]  first_word,
  output logic [31:0]  current_raw,
  output logic [31:0]  power_raw,
  output logic [31:0]  energy_raw,
  output logic [15:0]  frequency_raw,
  output logic [15:0]  power_factor_raw
);

  logic [7:0]         last_address;
  logic [7:0]         last_address_next;
  status_t            status_next;
  logic [COUNT_W-1:0] n;
  logic               word_ok;
  logic               metrics_ok;

  assign n = frame.count;

  always_comb begin
    last_address_next = last_address;
    if (n == '0) begin
      status_next = STATUS_TIMEOUT;
    end else if (n != COUNT_W'(cfg.expected_length)) begin
      status_next = STATUS_LENGTH;
    end else if ((n < MIN_FRAME_LEN) || (frame.crc != 16'h0000)) begin
      status_next = STATUS_CRC;
    end else begin
      last_address_next = frame.bytes[0];
      if ((cfg.expected_address != BROADCAST_ADDR) &&
          (cfg.expected_address != frame.bytes[0])) begin
        status_next = STATUS_ADDRESS;
      end else begin
        status_next = STATUS_OK;
      end
    end
  end

  assign word_ok    = (status_next == STATUS_OK) && (n >= MIN_WORD_LEN);
  assign metrics_ok = (status_next == STATUS_OK) && (n == METRICS_LEN);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_address <= '0;
      result_valid <= 1'b0;
    end else if (end_beat) begin
      last_address <= last_address_next;
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (end_beat) begin
      status         <= status_next;
      device_address <= last_address_next;
      byte_count     <= 6'(n);
      first_word     <= word_ok ? {frame.bytes[3], frame.bytes[4]} : 16'h0000;
      current_raw    <= metrics_ok ?
                        {frame.bytes[7], frame.bytes[8], frame.bytes[5], frame.bytes[6]} :
                        32'h0;
      power_raw      <= metrics_ok ?
                        {frame.bytes[11], frame.bytes[12], frame.bytes[9], frame.bytes[10]} :
                        32'h0;
      energy_raw     <= metrics_ok ?
                        {frame.bytes[15], frame.bytes[16], frame.bytes[13], frame.bytes[14]} :
                        32'h0;
      frequency_raw    <= metrics_ok ? {frame.bytes[17], frame.bytes[18]} : 16'h0000;
      power_factor_raw <= metrics_ok ? {frame.bytes[19], frame.bytes[20]} : 16'h0000;
    end
  end

endmodule

`default_nettype wire

>>> design/modbus_meter_response_checker.sv
// Modbus RTU reply checker: takes reply bytes one beat per cycle and, on the
// end beat, registers one status and the raw meter registers of the frame.
// A byte beat updates the frame store, the byte count and the crc in the
// cycle it is accepted; an end beat is checked in the same cycle and its
// result appears in the output register on the next cycle. The input takes
// one beat every cycle; it stalls only while a result waits in the output
// register and result_ready is low. Bytes beyond expected_length (or the
// 32-byte store) are dropped. Registers: expected_address at 0x0, and
// expected_length at 0x4.
// depends on mmrc_pkg, mmrc_frame and mmrc_result.
`default_nettype none

module modbus_meter_response_checker
  import mmrc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         item_valid,
  output logic         item_ready,
  input  logic         cmd,
  input  logic [7:0]   rx_byte,
  output logic         result_valid,
  input  logic         result_ready,
  output logic [2:0]   status,
  output logic [7:0]   device_address,
  output logic [5:0]   byte_count,
  output logic [15:0]  first_word,
  output logic [31:0]  current_raw,
  output logic [31:0]  power_raw,
  output logic [31:0]  energy_raw,
  output logic [15:0]  frequency_raw,
  output logic [15:0]  power_factor_raw
);

  cfg_t   cfg;
  frame_t frame;
  logic   beat;
  logic   end_beat;
  logic   cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_address <= RESET_EXP_ADDR;
      cfg.expected_length  <= RESET_EXP_LEN;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_EXP_ADDR: cfg.expected_address <= pwdata[7:0];
        REG_EXP_LEN:  cfg.expected_length  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_EXP_ADDR: prdata = {24'h0, cfg.expected_address};
      REG_EXP_LEN:  prdata = {26'h0, cfg.expected_length};
      default:      prdata = 32'h0;
    endcase
  end

  assign item_ready = !result_valid || result_ready;
  assign beat       = item_valid && item_ready;
  assign end_beat   = beat && (cmd == CMD_END);

  mmrc_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .beat    (beat),
    .cmd     (cmd),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .frame   (frame)
  );

  mmrc_result u_result (
    .clk              (clk),
    .rst              (rst),
    .end_beat         (end_beat),
    .frame            (frame),
    .cfg              (cfg),
    .result_ready     (result_ready),
    .result_valid     (result_valid),
    .status           (status),
    .device_address   (device_address),
    .byte_count       (byte_count),
    .first_word       (first_word),
    .current_raw      (current_raw),
    .power_raw        (power_raw),
    .energy_raw       (energy_raw),
    .frequency_raw    (frequency_raw),
    .power_factor_raw (power_factor_raw)
  );

endmodule

`default_nettype wire

>>> design/mmrc_checker.sv
// mmrc_checker: port-level checks of the modbus reply checker, with its bind.
// depends on mmrc_pkg and modbus_meter_response_checker.
`default_nettype none

module mmrc_checker
  import mmrc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        cmd,
  input logic        result_valid,
  input logic        result_ready,
  input logic [2:0]  status,
  input logic [5:0]  byte_count,
  input logic [15:0] first_word,
  input logic [31:0] current_raw,
  input logic [31:0] power_raw,
  input logic [31:0] energy_raw
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(status) &&
      $stable(byte_count) && $stable(current_raw))
    else $error("stalled result changed");

  // every end beat gives a result on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (cmd == CMD_END) |=> result_valid)
    else $error("end beat lost");

  // an empty frame is always a timeout, and only an empty frame
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((byte_count == 6'd0) == (status == STATUS_TIMEOUT)))
    else $error("timeout and byte count disagree");

  // metrics stay zero unless the frame passed
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (status != STATUS_OK) |->
      (first_word == 16'h0) && (current_raw == 32'h0) &&
      (power_raw == 32'h0) && (energy_raw == 32'h0))
    else $error("metrics on failed frame");

endmodule

bind modbus_meter_response_checker mmrc_checker u_mmrc_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .cmd          (cmd),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .status       (status),
  .byte_count   (byte_count),
  .first_word   (first_word),
  .current_raw  (current_raw),
  .power_raw    (power_raw),
  .energy_raw   (energy_raw)
);

`default_nettype wire

>>> dv/mmrc_tb_pkg.sv
// mmrc_tb_pkg: reply scoreboard for the modbus reply checker bench; tracks the
// frame, crc and expected-result queue and checks each result beat.
// depends on mmrc_pkg from the design.
package mmrc_tb_pkg;
  import mmrc_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  device_address;
    logic [5:0]  byte_count;
    logic [15:0] first_word;
    logic [31:0] current_raw;
    logic [31:0] power_raw;
    logic [31:0] energy_raw;
    logic [15:0] frequency_raw;
    logic [15:0] power_factor_raw;
  } reply_t;

  class reply_scoreboard;
    logic [7:0]  want_addr;
    logic [5:0]  want_len;
    logic [5:0]  frame_len;
    logic [15:0] crc;
    logic [7:0]  frame_bytes [FRAME_BYTES];
    logic [7:0]  seen_addr;
    reply_t      pending_replies [$];
    int          mismatches;
    int          beats_taken;
    int          replies_due;

    function new();
      want_addr   = RESET_EXP_ADDR;
      want_len    = RESET_EXP_LEN;
      frame_len   = '0;
      crc         = CRC_INIT;
      seen_addr   = 8'h00;
      mismatches  = 0;
      beats_taken = 0;
      replies_due = 0;
      foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
    endfunction

    static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] d);
      logic fb;
      for (int k = 0; k < 8; k++) begin
        fb = c[0] ^ d[k];
        c = c >> 1;
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function void set_register(reg_index_t idx, logic [31:0] value);
      if (idx == REG_EXP_ADDR) want_addr = value[7:0];
      else want_len = value[5:0];
    endfunction

    function void note_beat(cmd_t c, logic [7:0] b);
      reply_t r;
      if (c == CMD_BYTE) begin
        if (frame_len < want_len && frame_len < STORE_LIMIT) begin
          frame_bytes[frame_len] = b;
          crc = crc_next(crc, b);
          frame_len++;
          beats_taken++;
        end
        return;
      end
      beats_taken++;
      replies_due++;
      r = '0;
      if (frame_len == 0) r.status = STATUS_TIMEOUT;
      else if (frame_len != want_len) r.status = STATUS_LENGTH;
      else if (frame_len < MIN_FRAME_LEN || crc != 16'h0000) r.status = STATUS_CRC;
      else begin
        seen_addr = frame_bytes[0];
        if (want_addr != BROADCAST_ADDR && want_addr != seen_addr) r.status = STATUS_ADDRESS;
        else r.status = STATUS_OK;
      end
      r.device_address = seen_addr;
      r.byte_count = frame_len;
      if (r.status == STATUS_OK && frame_len >= MIN_WORD_LEN)
        r.first_word = {frame_bytes[3], frame_bytes[4]};
      if (r.status == STATUS_OK && frame_len == METRICS_LEN) begin
        r.current_raw = {frame_bytes[7], frame_bytes[8], frame_bytes[5], frame_bytes[6]};
        r.power_raw = {frame_bytes[11], frame_bytes[12], frame_bytes[9], frame_bytes[10]};
        r.energy_raw = {frame_bytes[15], frame_bytes[16], frame_bytes[13], frame_bytes[14]};
        r.frequency_raw = {frame_bytes[17], frame_bytes[18]};
        r.power_factor_raw = {frame_bytes[19], frame_bytes[20]};
      end
      pending_replies.push_back(r);
      frame_len = '0;
      crc = CRC_INIT;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result beat with nothing expected, status %0d", got.status);
        return;
      end
      want = pending_replies.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("device_address", want.device_address, got.device_address);
      compare_field("byte_count", want.byte_count, got.byte_count);
      compare_field("first_word", want.first_word, got.first_word);
      compare_field("current_raw", want.current_raw, got.current_raw);
      compare_field("power_raw", want.power_raw, got.power_raw);
      compare_field("energy_raw", want.energy_raw, got.energy_raw);
      compare_field("frequency_raw", want.frequency_raw, got.frequency_raw);
      compare_field("power_factor_raw", want.power_factor_raw, got.power_factor_raw);
    endfunction

    function int leftover();
      return pending_replies.size();
    endfunction
  endclass

endpackage

>>> dv/tb_top.sv
// tb_top: sends modbus reply frames to the checker through its beat and apb
// ports under several idle and stall mixes and checks every result beat.
// depends on mmrc_pkg, mmrc_tb_pkg and modbus_meter_response_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mmrc_pkg::*;
  import mmrc_tb_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 4;
  localparam int ITEM_TARGET  = 1050;
  localparam int REPLY_TARGET = 60;
  localparam int PHASE_BEATS  = 115;

  localparam int SEND_IDLE [4]  = '{0, 53, 0, 17};
  localparam int RECV_STALL [4] = '{0, 0, 53, 17};
  localparam logic [7:0] PHASE_ADDR [8] =
    '{8'hF8, 8'h00, 8'hFF, 8'hF8, 8'h5A, 8'hF8, 8'h00, 8'hA5};
  localparam logic [5:0] PHASE_LEN [8] =
    '{6'd23, 6'd3, 6'd32, 6'd5, 6'd23, 6'd9, 6'd23, 6'd17};
  localparam logic [5:0] ODD_LEN [5] = '{6'd0, 6'd1, 6'd2, 6'd40, 6'd63};

  typedef enum int {
    FRAME_GOOD, FRAME_BAD_CRC, FRAME_SHORT, FRAME_LONG, FRAME_EMPTY, FRAME_NOISE
  } frame_kind_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic        cmd = 1'b0;
  logic [7:0]  rx_byte = 8'h00;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [2:0]  status;
  logic [7:0]  device_address;
  logic [5:0]  byte_count;
  logic [15:0] first_word;
  logic [31:0] current_raw;
  logic [31:0] power_raw;
  logic [31:0] energy_raw;
  logic [15:0] frequency_raw;
  logic [15:0] power_factor_raw;

  reply_scoreboard reply_check;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  bit hold_go = 1'b0;
  int cycles = 0;

  modbus_meter_response_checker uut (.*);

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("modbus_meter_response_checker regression: fail");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready)
        reply_check.check_reply({status, device_address, byte_count, first_word,
                                 current_raw, power_raw, energy_raw,
                                 frequency_raw, power_factor_raw});
    end
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_taken) begin
        hold_left = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (rst) begin
        result_ready <= 1'b0;
      end else if (hold_left > 0) begin
        result_ready <= 1'b0;
        hold_left--;
      end else begin
        result_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_beat(cmd_t c, logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    cmd <= c;
    rx_byte <= b;
    do @(posedge clk); while (!item_ready);
    reply_check.note_beat(c, b);
  endtask

  task automatic write_register(reg_index_t idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    reply_check.set_register(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    item_valid <= 1'b0;
    while (reply_check.leftover() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [7:0] addr, logic [5:0] len);
    wait_quiet();
    write_register(REG_EXP_ADDR, {24'h0, addr});
    write_register(REG_EXP_LEN, {26'h0, len});
  endtask

  function automatic void seal(ref logic [7:0] body [$]);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (body[i]) c = reply_scoreboard::crc_next(c, body[i]);
    body.push_back(c[7:0]);
    body.push_back(c[15:8]);
  endfunction

  task automatic send_body(logic [7:0] body [$]);
    foreach (body[i]) send_beat(CMD_BYTE, body[i]);
    send_beat(CMD_END, 8'($urandom));
  endtask

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 60) return FRAME_GOOD;
    if (r < 70) return FRAME_BAD_CRC;
    if (r < 78) return FRAME_SHORT;
    if (r < 86) return FRAME_LONG;
    if (r < 90) return FRAME_EMPTY;
    return FRAME_NOISE;
  endfunction

  task automatic send_frame(frame_kind_t kind);
    logic [7:0] body [$];
    logic [7:0] addr;
    int n;
    int flip;
    int bitpos;
    n = reply_check.want_len;
    if (reply_check.want_addr == BROADCAST_ADDR || $urandom_range(99) < 15)
      addr = 8'($urandom);
    else
      addr = reply_check.want_addr;
    case (kind)
      FRAME_SHORT: n = (n > 1) ? $urandom_range(n - 1, 1) : 0;
      FRAME_EMPTY: n = 0;
      FRAME_NOISE: n = $urandom_range(40);
      default: ;
    endcase
    if (kind != FRAME_NOISE && n >= 3) begin
      body.push_back(addr);
      repeat (n - 3) body.push_back(8'($urandom));
      seal(body);
    end else begin
      repeat (n) body.push_back(8'($urandom));
    end
    if (kind == FRAME_BAD_CRC && body.size() > 0) begin
      flip = $urandom_range(body.size() - 1);
      bitpos = $urandom_range(7);
      body[flip] = body[flip] ^ (8'h01 << bitpos);
    end
    if (kind == FRAME_LONG)
      repeat ($urandom_range(4, 1)) body.push_back(8'($urandom));
    send_body(body);
  endtask

  task automatic run_frames(int beat_goal, int reply_goal);
    while (reply_check.beats_taken < beat_goal || reply_check.replies_due < reply_goal)
      send_frame(pick_kind());
  endtask

  initial begin
    logic [7:0] body [$];
    logic [5:0] len;
    int k;
    int goal;
    reply_check = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty frame, then a full metrics reply with all-ones registers
    send_beat(CMD_END, 8'h00);
    body = '{8'h00, 8'h04, 8'h12};
    repeat (18) body.push_back(8'hFF);
    seal(body);
    send_body(body);

    // lengths that can never pass
    foreach (ODD_LEN[i]) begin
      configure(BROADCAST_ADDR, ODD_LEN[i]);
      run_frames(reply_check.beats_taken + 12, 0);
    end

    for (int m = 0; m < 4; m++) begin
      for (int s = 0; s < 2; s++) begin
        k = 2 * m + s;
        len = (k == 7) ? 6'($urandom_range(32, 3)) : PHASE_LEN[k];
        configure(PHASE_ADDR[k], len);
        sender_idle_pct = SEND_IDLE[m];
        stall_pct = RECV_STALL[m];
        if (m == 2 && s == 0) hold_go = 1'b1;
        goal = reply_check.beats_taken + PHASE_BEATS;
        if (k == 7) begin
          if (goal < ITEM_TARGET) goal = ITEM_TARGET;
          run_frames(goal, REPLY_TARGET);
        end else begin
          run_frames(goal, 0);
        end
      end
    end

    wait_quiet();
    if (reply_check.mismatches == 0 && reply_check.leftover() == 0)
      $display("modbus_meter_response_checker regression: pass");
    else
      $display("modbus_meter_response_checker regression: fail");
    $finish;
  end

endmodule

>>> files.f
design/mmrc_pkg.sv
design/mmrc_frame.sv
design/mmrc_result.sv
design/modbus_meter_response_checker.sv
design/mmrc_checker.sv
dv/mmrc_tb_pkg.sv
dv/tb_top.sv
